// ===== rtl/core/ewqp_pkg.sv =====
`timescale 1ns / 1ps
// Shared package for the Q-form encoded-word encoder.
// Holds the ASCII constants, the beat descriptor, the configuration bundle and helpers.
// The front end, queue, back end, top level and testbench depend on it.
package ewqp_pkg;

  // Charset storage and queue sizing.
  localparam int CHARSET_MAX_BYTES = 16;
  localparam int CS_IDX_W          = $clog2(CHARSET_MAX_BYTES);
  localparam int CLEN_W            = 5;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed framing overhead of one encoded word beyond the charset name.
  localparam logic [7:0] PREFIX_EXTRA = 8'd5;
  localparam logic [8:0] FOLD_EXTRA   = 9'd6;

  // ASCII characters used in the framing and escapes.
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'd65;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CHARSET_LENGTH = 2'd0,
    CFG_CHARSET_LOW    = 2'd1,
    CFG_CHARSET_HIGH   = 2'd2,
    CFG_FOLD_LENGTH    = 2'd3
  } cfg_idx_t;

  // How the text byte of an item is written.
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_UNDER = 2'd1,
    KIND_HEX   = 2'd2
  } kind_t;

  // Output sequencer phases.
  typedef enum logic [3:0] {
    PH_EQ,
    PH_QM1,
    PH_CS,
    PH_QM2,
    PH_Q,
    PH_QM3,
    PH_BODY,
    PH_HEX_HI,
    PH_HEX_LO,
    PH_CLOSE_Q,
    PH_CLOSE_EQ,
    PH_SPACE
  } phase_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       prefix;
    logic       close;
    logic       space;
  } desc_t;

  // Derived configuration seen by the front and the back.
  typedef struct packed {
    logic [CLEN_W-1:0]              clen;
    logic [8*CHARSET_MAX_BYTES-1:0] charset;
    logic [7:0]                     limit;
  } cfg_t;

  // Upper-case hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

  // Bytes that may not appear unchanged inside a Q-form word.
  function automatic logic needs_escape(input logic [7:0] b);
    return b[7] || (b <= CH_SPACE) || (b == CH_DQUOTE) || (b == CH_UNDER) ||
           (b == CH_EQ) || (b == CH_QMARK);
  endfunction

endpackage

// ===== rtl/core/ewqp_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the encoder: one raw header byte and its end-of-run flag per beat.
// Stand-alone interface; no dependencies.
interface ewqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== rtl/core/ewqp_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the encoder: one encoded ASCII byte per beat.
// Stand-alone interface; no dependencies.
interface ewqp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;

  modport source (output valid, output out_byte, output last_of_item, input ready);
  modport sink   (input valid, input out_byte, input last_of_item, output ready);
endinterface

// ===== rtl/core/ewqp_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data per beat.
// Stand-alone interface; no dependencies.
interface ewqp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ewqp_front.sv =====
`timescale 1ns / 1ps
// Front end of the encoder: accepts input beats, classifies the byte and tracks
// the character count of the open encoded word. Depends on ewqp_pkg.
module ewqp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  ewqp_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic           final_byte,
  input  logic           queue_full,
  output logic           push,
  output ewqp_pkg::desc_t push_desc
);
  import ewqp_pkg::*;

  logic [7:0] count_r;
  logic [7:0] count_nxt;
  logic [7:0] base_count;
  logic [7:0] new_count;
  logic       close;
  kind_t      kind;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the byte.
  always_comb begin
    if (!needs_escape(data_byte)) begin
      kind = KIND_PLAIN;
    end else if (data_byte == CH_SPACE) begin
      kind = KIND_UNDER;
    end else begin
      kind = KIND_HEX;
    end
  end

  // Word length after this byte, and whether the word closes.
  always_comb begin
    base_count = (count_r == 8'd0) ? ({3'd0, cfg.clen} + PREFIX_EXTRA) : count_r;
    new_count  = base_count + ((kind == KIND_HEX) ? 8'd3 : 8'd1);
    close      = final_byte || (new_count >= cfg.limit);
    count_nxt  = close ? 8'd0 : new_count;
  end

  // Descriptor for the back end.
  always_comb begin
    push_desc.data   = data_byte;
    push_desc.kind   = kind;
    push_desc.prefix = (count_r == 8'd0);
    push_desc.close  = close;
    push_desc.space  = close && !final_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd0;
    end else if (push) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/ewqp_queue.sv =====
`timescale 1ns / 1ps
// Short descriptor queue between the front and the back end.
// Depends on ewqp_pkg for the descriptor type and depth.
module ewqp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ewqp_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ewqp_pkg::desc_t head_desc
);
  import ewqp_pkg::*;

  desc_t                  entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;

  assign full       = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid)) else $error("queue read while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// ===== rtl/core/ewqp_back.sv =====
`timescale 1ns / 1ps
// Back end of the encoder: walks each descriptor through prefix, text and close
// phases; an output register gives one byte per cycle unless the sink stalls. Depends on ewqp_pkg.
module ewqp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ewqp_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  ewqp_pkg::desc_t head_desc,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_item
);
  import ewqp_pkg::*;

  phase_t              phase_r;
  phase_t              phase_nxt;
  phase_t              phase_cur;
  logic                started_r;
  logic [CS_IDX_W-1:0] cs_idx_r;
  logic [CS_IDX_W-1:0] cs_idx_nxt;
  logic                fire;
  logic [7:0]          byte_cur;
  logic                last_cur;
  logic                cs_last;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  // A fresh descriptor starts at the prefix or straight at the text byte.
  assign phase_cur = started_r ? phase_r : (head_desc.prefix ? PH_EQ : PH_BODY);
  assign fire      = head_valid && (!out_valid_r || out_ready);
  assign pop       = fire && last_cur;
  assign cs_last   = ({1'b0, cs_idx_r} + 5'd1) == cfg.clen;

  // Next phase.
  always_comb begin
    phase_nxt  = phase_cur;
    cs_idx_nxt = cs_idx_r;
    unique case (phase_cur)
      PH_EQ:      phase_nxt = PH_QM1;
      PH_QM1: begin
        cs_idx_nxt = '0;
        phase_nxt  = (cfg.clen != '0) ? PH_CS : PH_QM2;
      end
      PH_CS: begin
        cs_idx_nxt = cs_idx_r + 1'b1;
        phase_nxt  = cs_last ? PH_QM2 : PH_CS;
      end
      PH_QM2:     phase_nxt = PH_Q;
      PH_Q:       phase_nxt = PH_QM3;
      PH_QM3:     phase_nxt = PH_BODY;
      PH_BODY:    phase_nxt = (head_desc.kind == KIND_HEX) ? PH_HEX_HI : PH_CLOSE_Q;
      PH_HEX_HI:  phase_nxt = PH_HEX_LO;
      PH_HEX_LO:  phase_nxt = PH_CLOSE_Q;
      PH_CLOSE_Q: phase_nxt = PH_CLOSE_EQ;
      PH_CLOSE_EQ: phase_nxt = PH_SPACE;
      PH_SPACE:   phase_nxt = PH_EQ;
      default:    phase_nxt = PH_EQ;
    endcase
  end

  // Byte emitted in the current phase and whether it ends the item.
  always_comb begin
    byte_cur = CH_QMARK;
    last_cur = 1'b0;
    unique case (phase_cur)
      PH_EQ:      byte_cur = CH_EQ;
      PH_QM1:     byte_cur = CH_QMARK;
      PH_CS:      byte_cur = cfg.charset[cs_idx_r*8 +: 8];
      PH_QM2:     byte_cur = CH_QMARK;
      PH_Q:       byte_cur = CH_Q;
      PH_QM3:     byte_cur = CH_QMARK;
      PH_BODY: begin
        case (head_desc.kind)
          KIND_PLAIN: byte_cur = head_desc.data;
          KIND_UNDER: byte_cur = CH_UNDER;
          default:    byte_cur = CH_EQ;
        endcase
        last_cur = (head_desc.kind != KIND_HEX) && !head_desc.close;
      end
      PH_HEX_HI:  byte_cur = hex_digit(head_desc.data[7:4]);
      PH_HEX_LO: begin
        byte_cur = hex_digit(head_desc.data[3:0]);
        last_cur = !head_desc.close;
      end
      PH_CLOSE_Q: byte_cur = CH_QMARK;
      PH_CLOSE_EQ: begin
        byte_cur = CH_EQ;
        last_cur = !head_desc.space;
      end
      PH_SPACE: begin
        byte_cur = CH_SPACE;
        last_cur = 1'b1;
      end
      default:    byte_cur = CH_QMARK;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_EQ;
      started_r <= 1'b0;
      cs_idx_r  <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      started_r <= !last_cur;
      cs_idx_r  <= cs_idx_nxt;
    end
  end

  // Output register: takes a new byte whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_cur;
      out_last_r <= last_cur;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign last_of_item = out_last_r;

  a_started_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> head_valid) else $error("item in progress without a queued descriptor");
  a_hex_phase_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (started_r && (phase_r == PH_HEX_HI || phase_r == PH_HEX_LO)) |->
    (head_desc.kind == KIND_HEX)) else $error("hex digit phase for a non-escaped byte");
  a_space_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (started_r && phase_r == PH_SPACE) |-> head_desc.space)
    else $error("separator space on a final byte");
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && out_last_r)) else $error("item retired without a last beat");

endmodule

// ===== rtl/core/encoded_word_qp_encoder.sv =====
`timescale 1ns / 1ps
// Q-form encoded-word encoder. Each input beat carries one header byte and a flag for
// the last byte of a run; the block emits the encoded text one ASCII byte per output
// beat, with last_of_item high on the final beat of each input. A word opens with
// "=?", the charset and "?Q?" (charset_length + 5 bytes) and closes with "?=", plus a
// space when more bytes of the run follow. An input yields 1 output byte for a plain
// byte or a space and 3 for an escaped byte, plus the prefix when a word opens and 2 or
// 3 bytes when it closes, all carried on the single output byte lane. A four-entry
// descriptor queue lets input beats be taken while earlier items are still being
// written, and the output register holds a byte while the sink stalls. An accepted beat
// reaches the output through the queue and the output register. Configuration writes take
// effect at once and are to be made only while no item is in flight.
module encoded_word_qp_encoder (
  input  logic              clk,
  input  logic              rst_n,
  ewqp_cfg_if.sink          cfg_ch,
  ewqp_in_if.sink           in_ch,
  ewqp_out_if.source        out_ch
);
  import ewqp_pkg::*;

  logic [4:0]  charset_length_r;
  logic [63:0] charset_low_r;
  logic [63:0] charset_high_r;
  logic [7:0]  fold_length_r;
  cfg_t        cfg;
  logic [8:0]  fold_floor;
  logic        queue_full;
  logic        push;
  desc_t       push_desc;
  logic        pop;
  logic        head_valid;
  desc_t       head_desc;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_length_r <= 5'd10;
      charset_low_r    <= 64'd0;
      charset_high_r   <= 64'd0;
      fold_length_r    <= 8'd70;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_CHARSET_LENGTH: charset_length_r <= cfg_ch.data[4:0];
        CFG_CHARSET_LOW:    charset_low_r    <= cfg_ch.data;
        CFG_CHARSET_HIGH:   charset_high_r   <= cfg_ch.data;
        CFG_FOLD_LENGTH:    fold_length_r    <= cfg_ch.data[7:0];
        default:            charset_length_r <= charset_length_r;
      endcase
    end
  end

  // Clamped charset length and word limit.
  always_comb begin
    cfg.clen    = (charset_length_r > CLEN_W'(CHARSET_MAX_BYTES)) ?
                  CLEN_W'(CHARSET_MAX_BYTES) : charset_length_r;
    cfg.charset = {charset_high_r, charset_low_r};
    fold_floor  = FOLD_EXTRA + {4'd0, cfg.clen};
    cfg.limit   = ({1'b0, fold_length_r} >= fold_floor) ?
                  8'({1'b0, fold_length_r} - fold_floor) : 8'd0;
  end

  ewqp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  ewqp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  ewqp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_desc    (head_desc),
    .pop          (pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .last_of_item (out_ch.last_of_item)
  );

endmodule

// ===== verif/tb_encoded_word_qp_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Q-form encoded-word encoder: random and directed header
// bytes under several charset and fold settings, each output beat checked against a local
// encoder model. Depends on ewqp_pkg and the three channel interfaces of the RTL.
module tb_encoded_word_qp_encoder;
  import ewqp_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_TICKS = 20;

  // One header byte waiting to be sent, with its idle gap and hold-off request.
  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         drain;
    int         gap;
  } hdr_beat_t;

  // One encoded character the block must still produce.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic clk;
  logic rst_n;

  ewqp_cfg_if cfg_ch ();
  ewqp_in_if  in_ch ();
  ewqp_out_if out_ch ();

  encoded_word_qp_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the configuration and the open-word character count.
  logic [4:0]  cs_len;
  logic [63:0] cs_low;
  logic [63:0] cs_high;
  logic [7:0]  fold_len;
  logic [7:0]  word_len;

  hdr_beat_t send_q[$];
  enc_char_t encoded_chars_q[$];
  hdr_beat_t cur_beat;

  bit in_active;
  bit in_beat_done;
  bit out_beat_done;
  int out_hold;
  bit send_gaps_on;
  bit recv_stalls_on;
  int mismatches;
  int cycle_count;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Upper-case hex character of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return "0" + {4'd0, nib};
    end
    return "A" - 8'd10 + {4'd0, nib};
  endfunction

  // Encode one header byte and append the characters it produces to the expected stream.
  function automatic void q_encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0]   word_chars[$];
    logic [127:0] cs_name;
    int           clen;
    int           lim;
    int           cnt;
    bit           esc;
    cs_name = {cs_high, cs_low};
    clen = (cs_len > 5'd16) ? 16 : int'(cs_len);
    lim = (int'(fold_len) >= 6 + clen) ? int'(fold_len) - 6 - clen : 0;
    cnt = int'(word_len);

    // Open a new word with the prefix.
    if (cnt == 0) begin
      word_chars.push_back("=");
      word_chars.push_back("?");
      for (int i = 0; i < clen; i++) begin
        word_chars.push_back(cs_name[8*i +: 8]);
      end
      word_chars.push_back("?");
      word_chars.push_back("Q");
      word_chars.push_back("?");
      cnt = clen + 5;
    end

    // The text byte itself.
    esc = b[7] || (b <= 8'h20) || (b == "\"") || (b == "_") || (b == "=") || (b == "?");
    if (!esc) begin
      word_chars.push_back(b);
      cnt = cnt + 1;
    end else if (b == " ") begin
      word_chars.push_back("_");
      cnt = cnt + 1;
    end else begin
      word_chars.push_back("=");
      word_chars.push_back(hex_char(b[7:4]));
      word_chars.push_back(hex_char(b[3:0]));
      cnt = cnt + 3;
    end

    // Close the word at the end of the run or once it is full.
    if (fin || cnt >= lim) begin
      word_chars.push_back("?");
      word_chars.push_back("=");
      if (!fin) begin
        word_chars.push_back(" ");
      end
      cnt = 0;
    end

    word_len = 8'(cnt);
    foreach (word_chars[k]) begin
      encoded_chars_q.push_back('{word_chars[k], (k == word_chars.size() - 1)});
    end
  endfunction

  // Input driver: presents queued bytes after their gap, holding off where a drain is asked.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_beat_done) begin
        in_beat_done = 1'b0;
        in_active = 1'b0;
      end
      if (!in_active && send_q.size() > 0) begin
        if (send_q[0].gap > 0) begin
          send_q[0].gap = send_q[0].gap - 1;
        end else if (!(send_q[0].drain && encoded_chars_q.size() > 0)) begin
          cur_beat = send_q.pop_front();
          in_active = 1'b1;
          in_ch.data_byte  <= cur_beat.data;
          in_ch.final_byte <= cur_beat.fin;
        end
      end
      in_ch.valid <= in_active;
    end
  end

  // Output ready: a random stall after each beat taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_beat_done) begin
        out_beat_done = 1'b0;
        out_hold = recv_stalls_on ? $urandom_range(0, 5) : 0;
      end
      if (out_hold > 0) begin
        out_hold = out_hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted input beat, check each accepted output beat.
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        q_encode_byte(in_ch.data_byte, in_ch.final_byte);
        in_beat_done = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_beat_done = 1'b1;
        if (encoded_chars_q.size() == 0) begin
          $error("unexpected output beat: out_byte 0x%02h last_of_item %0b",
                 out_ch.out_byte, out_ch.last_of_item);
          mismatches++;
        end else begin
          want = encoded_chars_q.pop_front();
          if (out_ch.out_byte !== want.ch) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.ch, out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.last_of_item !== want.last) begin
            $error("last_of_item: expected %0b, got %0b", want.last, out_ch.last_of_item);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[encoded_word_qp_encoder] ERROR");
      $finish;
    end
  end

  // Queue one header byte with a gap drawn for the current idling mode.
  task automatic queue_byte(input logic [7:0] b, input logic fin, input bit drain);
    hdr_beat_t beat;
    beat.data  = b;
    beat.fin   = fin;
    beat.drain = drain;
    beat.gap   = send_gaps_on ? $urandom_range(0, 5) : 0;
    send_q.push_back(beat);
  endtask

  // Queue a run of random header bytes; the last one always ends the run.
  task automatic queue_random_run(input int count, input int final_odds);
    logic [7:0] b;
    logic       fin;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: b = 8'($urandom_range(0, 255));
        1: b = 8'($urandom_range(8'h21, 8'h7E));
        2: b = 8'($urandom_range(8'h00, 8'h20));
        3: b = 8'($urandom_range(8'h80, 8'hFF));
        default: begin
          case ($urandom_range(0, 4))
            0: b = " ";
            1: b = "\"";
            2: b = "_";
            3: b = "=";
            default: b = "?";
          endcase
        end
      endcase
      fin = (i == count - 1) || ($urandom_range(0, final_odds - 1) == 0);
      queue_byte(b, fin, ($urandom_range(0, 39) == 0));
    end
  endtask

  // Wait until every queued byte is sent and every expected character has come out.
  task automatic wait_encoder_idle();
    while (send_q.size() != 0 || in_active || encoded_chars_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // One configuration register write; the local copy follows it.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    case (idx)
      CFG_CHARSET_LENGTH: cs_len = val[4:0];
      CFG_CHARSET_LOW:    cs_low = val;
      CFG_CHARSET_HIGH:   cs_high = val;
      CFG_FOLD_LENGTH:    fold_len = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Write all four registers.
  task automatic set_word_format(input logic [4:0] clen, input logic [63:0] lo,
                                 input logic [63:0] hi, input logic [7:0] fold);
    write_reg(CFG_CHARSET_LENGTH, {59'd0, clen});
    write_reg(CFG_CHARSET_LOW, lo);
    write_reg(CFG_CHARSET_HIGH, hi);
    write_reg(CFG_FOLD_LENGTH, {56'd0, fold});
  endtask

  // Stimulus sequence.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.final_byte = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CHARSET_LENGTH;
    cfg_ch.data = 64'd0;
    cs_len = 5'd10;
    cs_low = 64'd0;
    cs_high = 64'd0;
    fold_len = 8'd70;
    word_len = 8'd0;
    in_active = 1'b0;
    in_beat_done = 1'b0;
    out_beat_done = 1'b0;
    out_hold = 0;
    mismatches = 0;
    cycle_count = 0;
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: plain, space, every escaped class and the printable edges.
    queue_byte(8'h41, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(" ", 1'b0, 1'b0);
    queue_byte("\"", 1'b0, 1'b0);
    queue_byte("_", 1'b0, 1'b1);
    queue_byte("=", 1'b0, 1'b0);
    queue_byte("?", 1'b0, 1'b0);
    queue_byte(8'h7F, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h21, 1'b0, 1'b0);
    queue_byte(8'h7E, 1'b0, 1'b0);
    queue_byte(8'h0A, 1'b0, 1'b0);
    queue_byte(8'h7A, 1'b1, 1'b0);
    wait_encoder_idle();

    // A common ten-byte charset at the usual fold.
    set_word_format(5'd10, 64'h3935_3838_2D6F_7369, 64'h0000_0000_0000_312D, 8'd70);
    queue_random_run(45, 10);
    wait_encoder_idle();

    // No charset bytes at the smallest nominal fold, back to back on both sides.
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b0;
    set_word_format(5'd0, 64'd0, 64'd0, 8'd44);
    queue_byte("=", 1'b0, 1'b0);
    queue_byte(" ", 1'b0, 1'b0);
    queue_byte(8'h09, 1'b1, 1'b0);
    queue_random_run(40, 12);
    wait_encoder_idle();

    // Oversized charset length and a zero fold: every word overflows at once.
    send_gaps_on = 1'b1;
    set_word_format(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    queue_byte(8'h41, 1'b0, 1'b0);
    queue_byte(8'hC3, 1'b1, 1'b0);
    queue_random_run(30, 8);
    wait_encoder_idle();

    // Full charset and the widest fold: long words.
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b1;
    set_word_format(5'd16, {$urandom, $urandom}, {$urandom, $urandom}, 8'd255);
    queue_random_run(50, 60);
    wait_encoder_idle();

    // One-byte charset with the limit exactly at zero.
    send_gaps_on = 1'b1;
    set_word_format(5'd1, 64'h0000_0000_0000_0061, 64'd0, 8'd7);
    queue_random_run(20, 6);
    wait_encoder_idle();

    // Short charset at a typical line length.
    set_word_format(5'd5, 64'h0000_0038_2D46_5455, 64'd0, 8'd76);
    queue_random_run(60, 15);
    wait_encoder_idle();

    // Random settings across the whole register range.
    for (int p = 0; p < 4; p++) begin
      send_gaps_on = $urandom_range(0, 1);
      recv_stalls_on = $urandom_range(0, 1);
      set_word_format(5'($urandom_range(0, 31)), {$urandom, $urandom}, {$urandom, $urandom},
                      8'($urandom_range(0, 255)));
      queue_random_run(25, 10);
      wait_encoder_idle();
    end

    repeat (SETTLE_TICKS) @(negedge clk);
    if (mismatches == 0 && encoded_chars_q.size() == 0) begin
      $display("[encoded_word_qp_encoder] OK");
    end else begin
      $display("[encoded_word_qp_encoder] ERROR");
    end
    $finish;
  end

endmodule
